### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define SAM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define SAM_ASSERT(lbl, prop, msg) \
  `SAM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`else

`define SAM_ASSERT_CLK(lbl, clk, rstn, prop, msg)

`define SAM_ASSERT(lbl, prop, msg)

`endif

`endif

### rtl/core/sam_pkg.sv
// ----------------------------------------------------------------------------
// Sprite attribute memory package
// Types and constants shared by the sprite attribute memory port.
// ----------------------------------------------------------------------------
package sam_pkg;

  localparam int unsigned TABLE_BYTES     = 160;
  localparam int unsigned LOW_RAM_BYTES   = 32;
  localparam int unsigned HIGH_RAM_BYTES  = 16;
  localparam int unsigned EXT_BYTES       = LOW_RAM_BYTES + HIGH_RAM_BYTES;
  localparam int unsigned LOW_AW          = $clog2(LOW_RAM_BYTES);
  localparam int unsigned HIGH_AW         = $clog2(HIGH_RAM_BYTES);
  localparam int unsigned EXT_AW          = $clog2(EXT_BYTES);
  localparam logic [7:0]  HIGH_RAM_START  = 8'hC0;
  localparam logic [7:0]  BLOCKED_DATA    = 8'hFF;
  localparam logic [7:0]  ZERO_DATA       = 8'h00;

  typedef enum logic [1:0] {
    MODE_CPU_RD = 2'd0,
    MODE_CPU_WR = 2'd1,
    MODE_PPU_RD = 2'd2,
    MODE_PPU_WR = 2'd3
  } sam_mode_e;

  typedef enum logic [1:0] {
    MODEL_DMG       = 2'd0,
    MODEL_CGB_EARLY = 2'd1,
    MODEL_CGB_LATE  = 2'd2,
    MODEL_RSVD      = 2'd3
  } sam_model_e;

  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,
    SRC_TABLE = 2'd1,
    SRC_EXTRA = 2'd2
  } sam_src_e;

  typedef struct packed {
    logic       tab_re;
    logic       tab_we;
    logic       ext_re;
    logic       ext_we;
    sam_src_e   src;
    logic [7:0] const_data;
  } sam_ctrl_t;

endpackage

### rtl/core/sprite_attribute_memory_port_core.sv
// ----------------------------------------------------------------------------
// Sprite attribute memory port core
// Each access passes the s1 stage, then the output stage. Throughput is one
// access per cycle unless the output stalls, set by each RAM's single port.
// Reset clears the pipeline, the model register and the RAM valid bits, so
// all stored bytes read as zero after reset with no clearing pass.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sprite_attribute_memory_port_core
  import sam_pkg::*;
#(
  parameter int unsigned TableBytes = TABLE_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] mode_i,
  input  logic [7:0] address_i,
  input  logic [7:0] write_data_i,
  input  logic       cpu_access_allowed_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o
);

  localparam int unsigned TabAw = $clog2(TableBytes);

  sam_model_e  model_q;
  logic        s1_valid_q, s1_valid_d;
  sam_mode_e   s1_mode_q;
  logic [7:0]  s1_addr_q;
  logic [7:0]  s1_wdata_q;
  logic        s1_allowed_q;
  logic        s1_adv;
  logic        in_xfer;

  logic        out_valid_q, out_valid_d;
  sam_src_e    out_src_q;
  logic [7:0]  out_const_q;

  sam_ctrl_t         ctrl;
  logic [TabAw-1:0]  tab_addr;
  logic [EXT_AW-1:0] ext_addr;
  logic [7:0]        tab_rdata;
  logic [7:0]        ext_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_DMG;
    end else if (cfg_we_i) begin
      model_q <= sam_model_e'(cfg_wdata_i);
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_mode_q    <= sam_mode_e'(mode_i);
      s1_addr_q    <= address_i;
      s1_wdata_q   <= write_data_i;
      s1_allowed_q <= cpu_access_allowed_i;
    end
  end

  sam_decode #(
    .TableBytes (TableBytes),
    .TabAw      (TabAw)
  ) u_decode (
    .mode_i     (s1_mode_q),
    .address_i  (s1_addr_q),
    .allowed_i  (s1_allowed_q),
    .model_i    (model_q),
    .ctrl_o     (ctrl),
    .tab_addr_o (tab_addr),
    .ext_addr_o (ext_addr)
  );

  sam_ram #(
    .Depth (TableBytes),
    .Aw    (TabAw)
  ) u_table_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (s1_adv && ctrl.tab_re),
    .we_i    (s1_adv && ctrl.tab_we),
    .addr_i  (tab_addr),
    .wdata_i (s1_wdata_q),
    .rdata_o (tab_rdata)
  );

  sam_ram #(
    .Depth (EXT_BYTES),
    .Aw    (EXT_AW)
  ) u_extra_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (s1_adv && ctrl.ext_re),
    .we_i    (s1_adv && ctrl.ext_we),
    .addr_i  (ext_addr),
    .wdata_i (s1_wdata_q),
    .rdata_o (ext_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_src_q   <= ctrl.src;
      out_const_q <= ctrl.const_data;
    end
  end

  always_comb begin
    unique case (out_src_q)
      SRC_TABLE: read_data_o = tab_rdata;
      SRC_EXTRA: read_data_o = ext_rdata;
      default:   read_data_o = out_const_q;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `SAM_ASSERT(a_stage_holds, s1_valid_q && !s1_adv |=> s1_valid_q, "Stalled access was dropped")
  `SAM_ASSERT(a_one_store, !(ctrl.tab_we && ctrl.ext_we), "Access writes both RAMs")
  `SAM_ASSERT(a_write_zero, s1_valid_q && (s1_mode_q == MODE_CPU_WR || s1_mode_q == MODE_PPU_WR) |-> ctrl.src == SRC_CONST && ctrl.const_data == ZERO_DATA, "Write result is not zero")
  `SAM_ASSERT(a_blocked_read, s1_adv && s1_mode_q == MODE_CPU_RD && !s1_allowed_q |=> out_valid_q && out_src_q == SRC_CONST && out_const_q == BLOCKED_DATA, "Blocked read not 0xFF")
  `SAM_ASSERT(a_extra_model, ctrl.ext_we || ctrl.ext_re |-> model_q == MODEL_CGB_EARLY, "Extra RAM used under wrong model")

endmodule

### rtl/core/sam_ram.sv
// ----------------------------------------------------------------------------
// Sprite attribute memory RAM
// Single-port byte RAM with registered read data and per-entry valid bits,
// so that entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module sam_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          re_i,
  input  logic          we_i,
  input  logic [Aw-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [Depth];
  logic       valid_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (we_i) begin
      valid_q[addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= valid_q[addr_i] ? mem_q[addr_i] : 8'h00;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sam_decode.sv
// ----------------------------------------------------------------------------
// Sprite attribute memory access decoder
// Turns one registered access into store enables, store addresses and the
// source of its result byte, following port mode, access rights and model.
// ----------------------------------------------------------------------------
module sam_decode
  import sam_pkg::*;
#(
  parameter int unsigned TableBytes = TABLE_BYTES,
  parameter int unsigned TabAw      = $clog2(TableBytes)
) (
  input  sam_mode_e        mode_i,
  input  logic [7:0]       address_i,
  input  logic             allowed_i,
  input  sam_model_e       model_i,
  output sam_ctrl_t        ctrl_o,
  output logic [TabAw-1:0] tab_addr_o,
  output logic [EXT_AW-1:0] ext_addr_o
);

  localparam logic [8:0] TabLimit = 9'(TableBytes);

  logic       in_tab;
  logic       in_high;
  logic [7:0] low_off;
  logic [7:0] unused_data;

  assign in_tab  = {1'b0, address_i} < TabLimit;
  assign in_high = address_i >= HIGH_RAM_START;
  assign low_off = address_i - TabLimit[7:0];

  assign tab_addr_o = TabAw'(address_i);
  assign ext_addr_o = in_high
                    ? EXT_AW'(LOW_RAM_BYTES) + EXT_AW'(address_i[HIGH_AW-1:0])
                    : EXT_AW'(low_off[LOW_AW-1:0]);

  assign unused_data = {address_i[7:4], address_i[7:4]};

  always_comb begin
    ctrl_o = '{tab_re: 1'b0, tab_we: 1'b0, ext_re: 1'b0, ext_we: 1'b0,
               src: SRC_CONST, const_data: ZERO_DATA};
    unique case (mode_i)
      MODE_CPU_RD: begin
        if (!allowed_i) begin
          ctrl_o.const_data = BLOCKED_DATA;
        end else if (in_tab) begin
          ctrl_o.tab_re = 1'b1;
          ctrl_o.src    = SRC_TABLE;
        end else begin
          unique case (model_i)
            MODEL_CGB_EARLY: begin
              ctrl_o.ext_re = 1'b1;
              ctrl_o.src    = SRC_EXTRA;
            end
            MODEL_CGB_LATE: begin
              ctrl_o.const_data = unused_data;
            end
            default: begin
              ctrl_o.const_data = ZERO_DATA;
            end
          endcase
        end
      end
      MODE_CPU_WR: begin
        if (allowed_i) begin
          if (in_tab) begin
            ctrl_o.tab_we = 1'b1;
          end else if (model_i == MODEL_CGB_EARLY) begin
            ctrl_o.ext_we = 1'b1;
          end
        end
      end
      MODE_PPU_RD: begin
        if (allowed_i || !in_tab) begin
          ctrl_o.const_data = BLOCKED_DATA;
        end else begin
          ctrl_o.tab_re = 1'b1;
          ctrl_o.src    = SRC_TABLE;
        end
      end
      MODE_PPU_WR: begin
        if (!allowed_i && in_tab) begin
          ctrl_o.tab_we = 1'b1;
        end
      end
      default: begin
        ctrl_o.src = SRC_CONST;
      end
    endcase
  end

endmodule
